>>> hw/rtl/wav_header_chunk_parser_assert.svh
// assertion macros for the wav header chunk parser
// needs clk and rst in the including module's scope
`ifndef WAV_HEADER_CHUNK_PARSER_ASSERT_SVH
`define WAV_HEADER_CHUNK_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WAVHDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WAVHDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wavhdr_pkg.sv
// shared types and constants of the wav header chunk parser
// no dependencies
package wavhdr_pkg;

  // chunk tags as they read little-endian from the stream
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [4:0]  MASTER_BYTES = 5'd12;
  localparam logic [4:0]  HDR_BYTES    = 5'd8;
  localparam logic [4:0]  FMT_BYTES    = 5'd16;
  localparam logic [31:0] FMT_LEN_MIN  = 32'd16;
  localparam logic [7:0]  UNK_MAX      = 8'hFF;
  localparam logic [15:0] REQ_FORMAT_RST = 16'd1;

  // result status codes
  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_SHORT_MST = 3'd1;
  localparam logic [2:0] ST_SHORT_FMT = 3'd2;
  localparam logic [2:0] ST_BAD_FMT   = 3'd3;
  localparam logic [2:0] ST_FMT_SMALL = 3'd4;
  localparam logic [2:0] ST_SHORT_SKP = 3'd5;
  localparam logic [2:0] ST_NO_DATA   = 3'd6;
  localparam logic [2:0] ST_NONE      = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MASTER,
    PH_HDR,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] riff_size;
    logic [15:0] fmt_code;
    logic [15:0] chan_count;
    logic [31:0] samp_rate;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
    logic [7:0]  unknown_chunks;
  } result_t;

endpackage

>>> hw/rtl/wavhdr_in_reg.sv
// input register of the wav header chunk parser
// depends on wavhdr_pkg
module wavhdr_in_reg
  import wavhdr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  beat_t in_beat,
  input  logic  take,
  output logic  held_valid,
  output beat_t held_beat
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_beat <= in_beat;
    end
  end

endmodule

>>> hw/rtl/wavhdr_parse.sv
// per-byte parse state machine: master header, chunk headers, fmt capture, skips
// depends on wavhdr_pkg
module wavhdr_parse
  import wavhdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  beat_t       beat,
  input  logic [15:0] required_format,
  output logic        res_hit,
  output logic        res_valid,
  output result_t     res,
  output phase_t      phase
);

  logic [4:0]   pos;
  logic [31:0]  tag;
  logic [31:0]  len;
  logic [32:0]  skip;
  logic [31:0]  riff;
  logic [127:0] fmt;
  logic [7:0]   unknown;

  phase_t       phase_next;
  logic [4:0]   pos_next;
  logic [31:0]  tag_next;
  logic [31:0]  len_next;
  logic [32:0]  skip_next;
  logic [31:0]  riff_next;
  logic [127:0] fmt_next;
  logic [7:0]   unknown_next;
  logic [2:0]   st;
  logic         live;
  logic         active;

  // next state and datapath
  always_comb begin
    logic [4:0]  pos_inc;
    logic [32:0] skip_len;
    logic        do_skip;
    phase_t      ph_cur;

    ph_cur       = beat.start_of_file ? PH_MASTER : phase;
    pos_next     = beat.start_of_file ? 5'd0 : pos;
    tag_next     = beat.start_of_file ? 32'd0 : tag;
    len_next     = beat.start_of_file ? 32'd0 : len;
    skip_next    = beat.start_of_file ? 33'd0 : skip;
    riff_next    = beat.start_of_file ? 32'd0 : riff;
    fmt_next     = beat.start_of_file ? 128'd0 : fmt;
    unknown_next = beat.start_of_file ? 8'd0 : unknown;
    phase_next   = ph_cur;
    st           = ST_NONE;
    live         = (ph_cur != PH_IDLE) && (ph_cur != PH_DONE);
    active       = fire && live;
    pos_inc      = pos_next + 5'd1;
    skip_len     = 33'd0;
    do_skip      = 1'b0;

    unique case (ph_cur)
      PH_MASTER: begin
        if (pos_next >= 5'd4 && pos_next < 5'd8) begin
          riff_next[{pos_next[1:0], 3'b000} +: 8] = beat.data_byte;
        end
        pos_next = pos_inc;
        if (pos_inc >= MASTER_BYTES) begin
          phase_next = PH_HDR;
          pos_next   = 5'd0;
          tag_next   = 32'd0;
          len_next   = 32'd0;
        end
      end
      PH_HDR: begin
        if (pos_next < 5'd4) begin
          tag_next[{pos_next[1:0], 3'b000} +: 8] = beat.data_byte;
        end else begin
          len_next[{pos_next[1:0], 3'b000} +: 8] = beat.data_byte;
        end
        pos_next = pos_inc;
        if (pos_inc >= HDR_BYTES) begin
          pos_next = 5'd0;
          if (tag_next == TAG_FMT) begin
            fmt_next   = 128'd0;
            phase_next = PH_FMT;
          end else if (tag_next == TAG_DATA) begin
            st = ST_DATA;
          end else begin
            if (tag_next != TAG_LIST && unknown_next != UNK_MAX) begin
              unknown_next = unknown_next + 8'd1;
            end
            skip_len = {1'b0, len_next} + {32'd0, len_next[0]};
            do_skip  = 1'b1;
          end
        end
      end
      PH_FMT: begin
        fmt_next[{pos_next[3:0], 3'b000} +: 8] = beat.data_byte;
        pos_next = pos_inc;
        if (pos_inc >= FMT_BYTES) begin
          pos_next = 5'd0;
          if (fmt_next[15:0] != required_format) begin
            st = ST_BAD_FMT;
          end else if (len_next < FMT_LEN_MIN) begin
            st = ST_FMT_SMALL;
          end else begin
            skip_len = {1'b0, len_next - FMT_LEN_MIN} + {32'd0, len_next[0]};
            do_skip  = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (skip_next != 33'd0) begin
          skip_next = skip_next - 33'd1;
        end
        if (skip_next == 33'd0) begin
          phase_next = PH_HDR;
          pos_next   = 5'd0;
          tag_next   = 32'd0;
          len_next   = 32'd0;
        end
      end
      default: begin
      end
    endcase

    // start a skip, or go straight to the next header when it is empty
    if (do_skip) begin
      skip_next = skip_len;
      if (skip_len == 33'd0) begin
        phase_next = PH_HDR;
        pos_next   = 5'd0;
        tag_next   = 32'd0;
        len_next   = 32'd0;
      end else begin
        phase_next = PH_SKIP;
      end
    end

    if (st == ST_NONE && beat.end_of_file) begin
      unique case (phase_next)
        PH_MASTER: st = ST_SHORT_MST;
        PH_FMT:    st = ST_SHORT_FMT;
        PH_SKIP:   st = ST_SHORT_SKP;
        default:   st = ST_NO_DATA;
      endcase
    end
    if (st != ST_NONE) begin
      phase_next = PH_DONE;
    end
  end

  // result outputs; res_hit says the held byte would give a result if parsed
  always_comb begin
    res_hit             = live && (st != ST_NONE);
    res_valid           = active && (st != ST_NONE);
    res.status          = st;
    res.riff_size       = (st == ST_SHORT_MST) ? 32'd0 : riff_next;
    res.fmt_code        = fmt_next[15:0];
    res.chan_count      = fmt_next[31:16];
    res.samp_rate       = fmt_next[63:32];
    res.bytes_per_sec   = fmt_next[95:64];
    res.frame_bytes     = fmt_next[111:96];
    res.sample_bits     = fmt_next[127:112];
    res.data_size       = (st == ST_DATA) ? len_next : 32'd0;
    res.unknown_chunks  = unknown_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos   <= 5'd0;
    end else if (active) begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      tag     <= tag_next;
      len     <= len_next;
      skip    <= skip_next;
      riff    <= riff_next;
      fmt     <= fmt_next;
      unknown <= unknown_next;
    end
  end

endmodule

>>> hw/rtl/wavhdr_out_reg.sv
// result register of the wav header chunk parser
// depends on wavhdr_pkg
module wavhdr_out_reg
  import wavhdr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

>>> hw/rtl/wav_header_chunk_parser.sv
// wav header chunk parser, top level: one file byte per beat in, one result per file out
// result path: an accepted byte is held in the input register and parsed from there,
//   and the result it gives is registered in the result register, which drives the result beat
// throughput: one byte per cycle; a byte waits in the input register only when it
//   gives a result while an earlier result beat is held and not taken
// reset: rst (synchronous) empties both registers, puts the parser idle and sets
//   required_format to 1; bytes before the first start-of-file are dropped
`include "wav_header_chunk_parser_assert.svh"

module wav_header_chunk_parser
  import wavhdr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // file byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] start_of_file
  input  logic         s_axis_tlast,   // end_of_file
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,   // riff_size, fmt_code, chan_count,
                                       // samp_rate, bytes_per_sec, frame_bytes,
                                       // sample_bits, data_size, unknown_chunks
  output logic [2:0]   m_axis_tuser,   // [2:0] status
  // format register write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  logic        held_valid;
  beat_t       held_beat;
  beat_t       in_beat;
  logic        fire;
  logic        res_hit;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  phase_t      phase;
  logic [15:0] required_format;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      required_format <= REQ_FORMAT_RST;
    end else if (cfg_valid) begin
      required_format <= cfg_data;
    end
  end

  assign in_beat.data_byte     = s_axis_tdata;
  assign in_beat.start_of_file = s_axis_tuser;
  assign in_beat.end_of_file   = s_axis_tlast;

  // a held byte is parsed unless it gives a result and the result register is
  // still full, so a result never has to wait inside the parser
  assign fire = held_valid && (!res_hit || !m_axis_tvalid || m_axis_tready);

  wavhdr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_beat    (in_beat),
    .take       (fire),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  // header walk: master header, chunk tags and sizes, fmt capture, skips
  wavhdr_parse u_parse (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .beat            (held_beat),
    .required_format (required_format),
    .res_hit         (res_hit),
    .res_valid       (res_valid),
    .res             (res),
    .phase           (phase)
  );

  wavhdr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // pack result fields, first field lowest
  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {out_res.unknown_chunks, out_res.data_size,
                         out_res.sample_bits, out_res.frame_bytes,
                         out_res.bytes_per_sec, out_res.samp_rate,
                         out_res.chan_count, out_res.fmt_code,
                         out_res.riff_size};

  // a result is only loaded into an empty or draining output register
  `WAVHDR_ASSERT_NOW(a_res_into_empty, res_valid, !m_axis_tvalid || m_axis_tready, "result while output full")
  // once a result is out the parser ignores bytes until the next file
  `WAVHDR_ASSERT_NEXT(a_done_after_res, res_valid, phase == PH_DONE, "parser not done after result")
  // data size only carries meaning with a found data chunk
  `WAVHDR_ASSERT_NOW(a_dsize_zero, m_axis_tvalid && m_axis_tuser != ST_DATA, m_axis_tdata[191:160] == 32'd0, "data size set without data chunk")

endmodule
